FILE: design/upq_pkg.sv
// shared types and codes for the unsorted array priority queue
`timescale 1ns / 1ps

package upq_pkg;

    localparam int DATA_BITS = 32;
    localparam int OCC_BITS  = 8;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t                     status;
        logic signed [DATA_BITS-1:0] data;
        logic [OCC_BITS-1:0]         occupancy;
    } upq_result_t;

endpackage

FILE: design/upq_mem.sv
// entry memory: one write port, one read port with registered read data
`timescale 1ns / 1ps

module upq_mem #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 40,
    parameter int AW    = 7
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/upq_ctrl.sv
// sequencer: enqueue append, dequeue scan for best entry, shift-down pass
`timescale 1ns / 1ps

module upq_ctrl #(
    parameter int CAPACITY      = 128,
    parameter int PRIORITY_BITS = 8,
    parameter int AW            = 7,
    parameter int CW            = 8,
    parameter int EW            = 40
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         op,
    input  logic signed [31:0]           item_data,
    input  logic [7:0]                   item_priority,
    output logic                         res_valid,
    input  logic                         res_take,
    output upq_pkg::upq_result_t         res,
    output logic                         we,
    output logic [AW-1:0]                wr_addr,
    output logic [EW-1:0]                wr_data,
    output logic                         rd_en,
    output logic [AW-1:0]                rd_addr,
    input  logic [EW-1:0]                rd_data
);

    import upq_pkg::*;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            issue_idx_reg, issue_idx_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [CW-1:0]            rd_idx_reg, rd_idx_next;
    logic [AW-1:0]            best_idx_reg, best_idx_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg, best_prio_next;
    logic [DATA_BITS-1:0]     best_data_reg, best_data_next;
    upq_result_t              res_reg, res_next;

    logic                     acc;
    logic                     issuing;
    logic                     full;
    logic                     shift_end;
    logic [CW-1:0]            wr_idx;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [PRIORITY_BITS-1:0] in_prio;

    assign acc       = item_valid && (state_reg == S_IDLE);
    assign issuing   = issue_idx_reg < count_reg;
    assign full      = count_reg == CW'(CAPACITY);
    assign shift_end = !issuing && !rd_valid_reg;
    assign wr_idx    = rd_idx_reg - CW'(1);
    assign rd_prio   = rd_data[EW-1:DATA_BITS];
    assign in_prio   = PRIORITY_BITS'(item_priority);

    assign item_stall = state_reg != S_IDLE;
    assign res_valid  = state_reg == S_DONE;
    assign res        = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (op == OP_DEQ && count_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                if (!issuing)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (shift_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next     = count_reg;
        issue_idx_next = issue_idx_reg;
        rd_valid_next  = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_data_next = best_data_reg;
        res_next       = res_reg;
        we             = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = {in_prio, item_data};
        rd_en          = 1'b0;
        rd_addr        = issue_idx_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                issue_idx_next = '0;
                if (acc)
                begin
                    res_next.data = '0;
                    if (op == OP_ENQ)
                    begin
                        if (full)
                        begin
                            res_next.status    = ST_FULL;
                            res_next.occupancy = OCC_BITS'(count_reg);
                        end
                        else
                        begin
                            we                 = 1'b1;
                            count_next         = count_reg + CW'(1);
                            res_next.status    = ST_OK;
                            res_next.occupancy = OCC_BITS'(count_reg + CW'(1));
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status    = ST_EMPTY;
                        res_next.occupancy = OCC_BITS'(count_reg);
                    end
                end
            end
            S_SCAN:
            begin
                rd_en         = issuing;
                rd_valid_next = issuing;
                rd_idx_next   = issue_idx_reg;
                if (issuing)
                begin
                    issue_idx_next = issue_idx_reg + CW'(1);
                end
                // first entry seeds, later ones must be strictly higher
                if (rd_valid_reg && (rd_idx_reg == '0 || rd_prio > best_prio_reg))
                begin
                    best_idx_next  = rd_idx_reg[AW-1:0];
                    best_prio_next = rd_prio;
                    best_data_next = rd_data[DATA_BITS-1:0];
                end
                if (!issuing)
                begin
                    issue_idx_next = CW'(best_idx_next) + CW'(1);
                end
            end
            S_SHIFT:
            begin
                rd_en         = issuing;
                rd_valid_next = issuing;
                rd_idx_next   = issue_idx_reg;
                if (issuing)
                begin
                    issue_idx_next = issue_idx_reg + CW'(1);
                end
                if (rd_valid_reg)
                begin
                    we      = 1'b1;
                    wr_addr = wr_idx[AW-1:0];
                    wr_data = rd_data;
                end
                if (shift_end)
                begin
                    count_next         = count_reg - CW'(1);
                    res_next.status    = ST_OK;
                    res_next.data      = best_data_reg;
                    res_next.occupancy = OCC_BITS'(count_reg - CW'(1));
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_data_reg <= best_data_next;
        res_reg       <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == S_IDLE || state_reg == S_SHIFT))
        else $error("memory write outside append or shift");

    a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (we && state_reg == S_SHIFT) |-> (CW'(wr_addr) + CW'(1) < count_reg))
        else $error("shift write beyond held entries");

    a_deq_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && op == OP_DEQ && count_reg != '0) |=> state_reg == S_SCAN)
        else $error("dequeue did not start a scan");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_DONE) |=> $stable(count_reg))
        else $error("count changed during scan or while result waits");

endmodule

FILE: design/unsorted_array_priority_queue_unit.sv
// top level: priority queue as an unsorted array with scan and shift-down dequeue
// enqueue and rejected ops: the result word passes the sequencer and output registers
// dequeue: one read per cycle over the entry memory, in a scan pass over all entries,
// then a shift pass from the winner to the end
// one item at a time; the next item is taken while the result word waits for the sink
// reset (rst_n, async, low): queue empty, no result pending; memory is not cleared
`timescale 1ns / 1ps

module unsorted_array_priority_queue_unit #(
    parameter int CAPACITY      = 128,
    parameter int PRIORITY_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    // item side
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                op,
    input  logic signed [31:0]  item_data,
    input  logic [7:0]          item_priority,
    // result side
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          status,
    output logic signed [31:0]  out_data,
    output logic [7:0]          occupancy
);

    import upq_pkg::*;

    // address bits for entries, count bits to also hold the full value
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // each memory word holds the priority above the data word
    localparam int EW = PRIORITY_BITS + DATA_BITS;

    logic           we;
    logic [AW-1:0]  wr_addr;
    logic [EW-1:0]  wr_data;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic [EW-1:0]  rd_data;

    logic           res_valid;
    logic           res_take;
    upq_result_t    res;

    // output word register, parts the sequencer from the sink
    logic           out_valid_reg, out_valid_next;
    upq_result_t    out_reg, out_next;

    upq_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (EW),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    upq_ctrl #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .AW            (AW),
        .CW            (CW),
        .EW            (EW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .item_data     (item_data),
        .item_priority (item_priority),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res           (res),
        .we            (we),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // the output register is free when empty or being drained this cycle
    assign res_take = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign out_data     = out_reg.data;
    assign occupancy    = out_reg.occupancy;

endmodule

FILE: tb/sv/tb_unsorted_array_priority_queue_unit.sv
// testbench for the unsorted array priority queue: queued stimulus, shadow queue, word checks
`timescale 1ns / 1ps

module tb_unsorted_array_priority_queue_unit;

    import upq_pkg::*;

    localparam int QCAP          = 128;
    localparam int QPRIO_BITS    = 8;
    localparam logic [7:0] PRIO_MASK = 8'((1 << QPRIO_BITS) - 1);
    localparam int RANDOM_ITEMS  = 400;
    // no idling once this few items are left to send
    localparam int TAIL_ITEMS    = 40;
    // drain time after the last result, sized above the longest dequeue
    localparam int DRAIN_CYCLES  = 300;
    // cycles with no accepted word while work is outstanding
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        op_t                op;
        logic signed [31:0] data;
        logic [7:0]         prio;
    } pq_item_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid    = 1'b0;
    logic               item_stall;
    logic               op            = 1'b0;
    logic signed [31:0] item_data     = '0;
    logic [7:0]         item_priority = '0;
    logic               result_valid;
    logic               result_stall  = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] out_data;
    logic [7:0]         occupancy;

    // items waiting to be sent and results waiting to arrive
    pq_item_t    pending_items[$];
    upq_result_t expected_results[$];

    // shadow copy of the queue contents
    logic signed [31:0] held_data [QCAP];
    logic [7:0]         held_prio [QCAP];
    int                 held_count = 0;

    // planned occupancy while building the stimulus
    int plan_count = 0;

    pq_item_t    cur_item;
    upq_result_t want;
    int          send_gap    = 0;
    int          hold_cnt    = 0;
    logic        tail_phase  = 1'b0;
    int          error_count = 0;
    int          idle_cycles = 0;

    unsorted_array_priority_queue_unit #(
        .CAPACITY      (QCAP),
        .PRIORITY_BITS (QPRIO_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .item_data     (item_data),
        .item_priority (item_priority),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .out_data      (out_data),
        .occupancy     (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // apply one item to the shadow queue and return the result word it gives
    function automatic upq_result_t serve_item(pq_item_t it);
        upq_result_t r;
        logic [7:0]  p;
        int          best;
        int          i;
        r.status    = ST_OK;
        r.data      = '0;
        p           = it.prio & PRIO_MASK;
        if (it.op == OP_ENQ)
        begin
            // full: nothing stored
            if (held_count >= QCAP)
                r.status = ST_FULL;
            else
            begin
                held_data[held_count] = it.data;
                held_prio[held_count] = p;
                held_count++;
            end
        end
        else if (held_count == 0)
        begin
            // empty: flag only, no sentinel
            r.status = ST_EMPTY;
        end
        else
        begin
            // strict compare keeps the earliest entry on a tie
            best = 0;
            for (i = 1; i < held_count; i++)
                if (held_prio[i] > held_prio[best])
                    best = i;
            r.data = held_data[best];
            // close the gap
            for (i = best; i + 1 < held_count; i++)
            begin
                held_data[i] = held_data[i + 1];
                held_prio[i] = held_prio[i + 1];
            end
            held_count--;
        end
        r.occupancy = 8'(held_count);
        return r;
    endfunction

    task automatic push_item(op_t o, logic [31:0] d, logic [7:0] p);
        pq_item_t it;
        it.op   = o;
        it.data = d;
        it.prio = p;
        pending_items.push_back(it);
        if (o == OP_ENQ && plan_count < QCAP)
            plan_count++;
        else if (o == OP_DEQ && plan_count > 0)
            plan_count--;
    endtask

    // priorities lean toward a few small values so ties are common
    function automatic logic [7:0] rand_prio();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 8'($urandom_range(0, 3));
        else if (pick < 50)
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] rand_data();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            return 32'h8000_0000;
        else if (pick < 6)
            return 32'h7FFF_FFFF;
        else if (pick < 8)
            return 32'hFFFF_FFFF;
        else if (pick < 10)
            return 32'h0000_0000;
        return $urandom;
    endfunction

    // driver: presents the next pending item word, holds it while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_results.push_back(serve_item(cur_item));
            tail_phase <= (pending_items.size() < TAIL_ITEMS);
            if (item_valid && item_stall)
            begin
                // stalled word stays as it is
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                if (!tail_phase && $urandom_range(0, 9) == 0)
                begin
                    // idle burst of random length, starting with this cycle
                    send_gap = $urandom_range(1, 19) - 1;
                    item_valid <= 1'b0;
                end
                else
                begin
                    cur_item = pending_items.pop_front();
                    item_valid    <= 1'b1;
                    op            <= cur_item.op;
                    item_data     <= cur_item.data;
                    item_priority <= cur_item.prio;
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted result word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, status %0d data %0d occupancy %0d",
                             $time, status, out_data, occupancy);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, status);
                        error_count++;
                    end
                    if (out_data !== want.data)
                    begin
                        $display("%0t: out_data mismatch, expected %0d, actual %0d",
                                 $time, want.data, out_data);
                        error_count++;
                    end
                    if (occupancy !== want.occupancy)
                    begin
                        $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                                 $time, want.occupancy, occupancy);
                        error_count++;
                    end
                end
            end
            // stall bursts run independently of result_valid
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result_stall <= 1'b1;
            end
            else if (!tail_phase && $urandom_range(0, 9) == 0)
            begin
                hold_cnt = $urandom_range(1, 19) - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // watchdog: only counts while something is still outstanding
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else if (item_valid || pending_items.size() > 0 || expected_results.size() > 0)
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog timeout, no word accepted for %0d cycles",
                         $time, idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int n;
        int pick;

        // directed: empty dequeue first
        push_item(OP_DEQ, 32'h0, 8'h00);
        // data and priority extremes, tie at the top priority
        push_item(OP_ENQ, 32'h7FFF_FFFF, 8'h00);
        push_item(OP_ENQ, 32'h8000_0000, 8'hFF);
        push_item(OP_ENQ, 32'hFFFF_FFFF, 8'hFF);
        push_item(OP_ENQ, 32'h0000_0000, 8'h80);
        push_item(OP_ENQ, 32'h5555_5555, 8'h55);
        push_item(OP_ENQ, 32'hAAAA_AAAA, 8'hAA);
        repeat (6) push_item(OP_DEQ, 32'hFFFF_FFFF, 8'hFF);
        // empty again
        push_item(OP_DEQ, 32'h1234_5678, 8'h5A);
        // three-way tie, then a later entry that outranks the rest
        push_item(OP_ENQ, 32'd1, 8'd7);
        push_item(OP_ENQ, 32'd2, 8'd7);
        push_item(OP_ENQ, 32'd3, 8'd7);
        push_item(OP_DEQ, 32'h0, 8'h00);
        push_item(OP_ENQ, 32'd4, 8'd9);
        repeat (4) push_item(OP_DEQ, 32'h0, 8'h00);

        n = 0;
        // mixed traffic, enqueue leaning
        repeat (100)
        begin
            pick = $urandom_range(0, 99);
            push_item(op_t'(pick < 60 ? OP_ENQ : OP_DEQ), rand_data(), rand_prio());
            n++;
        end
        // fill to capacity, poke at full, refill
        while (plan_count < QCAP)
        begin
            push_item(OP_ENQ, rand_data(), rand_prio());
            n++;
        end
        repeat (4) push_item(OP_ENQ, rand_data(), rand_prio());
        repeat (2) push_item(OP_DEQ, rand_data(), rand_prio());
        repeat (3) push_item(OP_ENQ, rand_data(), rand_prio());
        n += 9;
        // drain, mostly dequeues, down to empty
        while (plan_count > 0)
        begin
            pick = $urandom_range(0, 99);
            push_item(op_t'(pick < 85 ? OP_DEQ : OP_ENQ), rand_data(), rand_prio());
            n++;
        end
        repeat (2) push_item(OP_DEQ, rand_data(), rand_prio());
        n += 2;
        // balanced tail
        while (n < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            push_item(op_t'(pick < 50 ? OP_ENQ : OP_DEQ), rand_data(), rand_prio());
            n++;
        end

        wait (rst_n === 1'b1);
        do
            @(posedge clk);
        while (pending_items.size() > 0 || item_valid || expected_results.size() > 0);
        // late or extra result words show up here as unexpected
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() > 0)
        begin
            $display("%0t: %0d expected result words never arrived",
                     $time, expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
